@@ src/owbm_pkg.sv @@
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int LEN_W   = 10;
    localparam int PHASE_W = 4;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RLOW  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RWAIT = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RTAIL = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WLEAD = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WBODY = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WREC  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DLEAD = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DWAIT = 4'd8;
    localparam logic [PHASE_W-1:0] PH_DTAIL = 4'd9;

    // configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW_TIME = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] CFG_RESET_TAIL     = 3'd2;
    localparam logic [2:0] CFG_SLOT_LEAD      = 3'd3;
    localparam logic [2:0] CFG_WRITE_HOLD     = 3'd4;
    localparam logic [2:0] CFG_SLOT_RECOVERY  = 3'd5;
    localparam logic [2:0] CFG_READ_WAIT      = 3'd6;
    localparam logic [2:0] CFG_READ_TAIL      = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0] reset_low_time;
        logic [LEN_W-1:0] presence_wait;
        logic [LEN_W-1:0] reset_tail;
        logic [LEN_W-1:0] slot_lead;
        logic [LEN_W-1:0] write_hold;
        logic [LEN_W-1:0] slot_recovery;
        logic [LEN_W-1:0] read_wait;
        logic [LEN_W-1:0] read_tail;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [1:0]         operation;
        logic [LEN_W-1:0]   tick_count;
        logic [2:0]         bit_index;
        logic [7:0]         shift_data;
        logic               presence_flag;
        logic [7:0]         last_read;
    } state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_IDLE,
        operation:     2'd0,
        tick_count:    '0,
        bit_index:     3'd0,
        shift_data:    8'd0,
        presence_flag: 1'b0,
        last_read:     8'd0
    };

endpackage

@@ src/one_wire_bus_master_unit.sv @@
`timescale 1ns / 1ps

// 1-Wire bus master sequencer, stepped by input beats.
// Input channel (in_valid/in_ready): one beat per bus tick (1 us); req_type
// 0 is a plain tick, 1 starts a reset/presence cycle, 2 a byte write
// (write_byte, LSB first), 3 a byte read. The beat that starts an operation
// is its first tick. A command while busy is dropped and flagged rejected.
// Output channel (out_valid/out_ready): one result beat per input beat with
// drive_low for that tick, busy/done flags, last presence and last read byte.
// Configuration: cfg_we writes cfg_data into timing register cfg_index;
// write only while the sequencer is idle and no beats are in flight.
// The input register takes the accepted beat; the result register then loads
// from the step logic once it is free or being drained, and raises out_valid.
// Throughput: one beat per cycle while out_ready stays high.
// Reset: timing registers take their defaults, sequencer idle, no beats held.
// When out_ready is low the result register holds and the input register
// fills, after which in_ready drops; nothing is lost or repeated.
module one_wire_bus_master_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [7:0]                 write_byte,
    input  logic                       line_level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence,
    output logic [7:0]                 read_byte,
    output logic                       rejected,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [owbm_pkg::LEN_W-1:0] cfg_data
);

    owbm_pkg::cfg_t    cfg;
    owbm_pkg::state_t  state_reg;
    owbm_pkg::state_t  state_next;
    owbm_pkg::result_t res_next;
    owbm_pkg::result_t res_reg;

    logic       in_vld_reg;
    logic [1:0] req_reg;
    logic [7:0] wbyte_reg;
    logic       line_reg;
    logic       out_vld_reg;
    logic       advance;

    owbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .req_type   (req_reg),
        .write_byte (wbyte_reg),
        .line_level (line_reg),
        .state_nxt  (state_next),
        .res        (res_next)
    );

    // result register free or being drained this cycle
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= owbm_pkg::STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
            if (advance && in_vld_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg   <= req_type;
            wbyte_reg <= write_byte;
            line_reg  <= line_level;
        end
        if (advance && in_vld_reg)
            res_reg <= res_next;
    end

    assign out_valid  = out_vld_reg;
    assign drive_low  = res_reg.drive_low;
    assign busy_res   = res_reg.busy_res;
    assign done_res   = res_reg.done_res;
    assign presence   = res_reg.presence;
    assign read_byte  = res_reg.read_byte;
    assign rejected   = res_reg.rejected;

endmodule

@@ src/owbm_cfg.sv @@
`timescale 1ns / 1ps

module owbm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [owbm_pkg::LEN_W-1:0]    cfg_data,
    output owbm_pkg::cfg_t                cfg
);

    owbm_pkg::cfg_t cfg_reg;
    owbm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                owbm_pkg::CFG_RESET_LOW_TIME: cfg_next.reset_low_time = cfg_data;
                owbm_pkg::CFG_PRESENCE_WAIT:  cfg_next.presence_wait  = cfg_data;
                owbm_pkg::CFG_RESET_TAIL:     cfg_next.reset_tail     = cfg_data;
                owbm_pkg::CFG_SLOT_LEAD:      cfg_next.slot_lead      = cfg_data;
                owbm_pkg::CFG_WRITE_HOLD:     cfg_next.write_hold     = cfg_data;
                owbm_pkg::CFG_SLOT_RECOVERY:  cfg_next.slot_recovery  = cfg_data;
                owbm_pkg::CFG_READ_WAIT:      cfg_next.read_wait      = cfg_data;
                owbm_pkg::CFG_READ_TAIL:      cfg_next.read_tail      = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time <= 10'd480;
            cfg_reg.presence_wait  <= 10'd70;
            cfg_reg.reset_tail     <= 10'd410;
            cfg_reg.slot_lead      <= 10'd2;
            cfg_reg.write_hold     <= 10'd60;
            cfg_reg.slot_recovery  <= 10'd2;
            cfg_reg.read_wait      <= 10'd10;
            cfg_reg.read_tail      <= 10'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/owbm_step.sv @@
`timescale 1ns / 1ps

module owbm_step (
    input  owbm_pkg::cfg_t    cfg,
    input  owbm_pkg::state_t  state_cur,
    input  logic [1:0]        req_type,
    input  logic [7:0]        write_byte,
    input  logic              line_level,
    output owbm_pkg::state_t  state_nxt,
    output owbm_pkg::result_t res
);

    owbm_pkg::state_t         s;
    logic [owbm_pkg::LEN_W-1:0] len_raw;
    logic [owbm_pkg::LEN_W-1:0] len;
    logic [owbm_pkg::LEN_W-1:0] tick_inc;
    logic                     cur_bit;
    logic                     drive;
    logic                     done;
    logic                     rej;

    always_comb
    begin
        s        = state_cur;
        drive    = 1'b0;
        done     = 1'b0;
        rej      = 1'b0;
        len_raw  = cfg.read_tail;
        len      = '0;
        tick_inc = '0;
        cur_bit  = 1'b0;

        if (req_type != owbm_pkg::REQ_TICK)
        begin
            if (s.phase != owbm_pkg::PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                s.operation  = req_type;
                s.tick_count = '0;
                s.bit_index  = 3'd0;
                case (req_type)
                    owbm_pkg::REQ_RESET: s.phase = owbm_pkg::PH_RLOW;
                    owbm_pkg::REQ_WRITE:
                    begin
                        s.phase      = owbm_pkg::PH_WLEAD;
                        s.shift_data = write_byte;
                    end
                    default:
                    begin
                        s.phase      = owbm_pkg::PH_DLEAD;
                        s.shift_data = 8'd0;
                    end
                endcase
            end
        end

        if (s.phase != owbm_pkg::PH_IDLE)
        begin
            cur_bit = s.shift_data[s.bit_index];
            if (s.phase inside {owbm_pkg::PH_RLOW, owbm_pkg::PH_WLEAD, owbm_pkg::PH_DLEAD})
                drive = 1'b1;
            else if (s.phase == owbm_pkg::PH_WBODY && !cur_bit)
                drive = 1'b1;

            case (s.phase)
                owbm_pkg::PH_RLOW:  len_raw = cfg.reset_low_time;
                owbm_pkg::PH_RWAIT: len_raw = cfg.presence_wait;
                owbm_pkg::PH_RTAIL: len_raw = cfg.reset_tail;
                owbm_pkg::PH_WLEAD: len_raw = cfg.slot_lead;
                owbm_pkg::PH_WBODY: len_raw = cfg.write_hold;
                owbm_pkg::PH_WREC:  len_raw = cfg.slot_recovery;
                owbm_pkg::PH_DLEAD: len_raw = cfg.slot_lead;
                owbm_pkg::PH_DWAIT: len_raw = cfg.read_wait;
                default:            len_raw = cfg.read_tail;
            endcase
            // a zero length behaves as one tick
            len = (len_raw == '0) ? owbm_pkg::LEN_W'(1) : len_raw;

            tick_inc = s.tick_count + owbm_pkg::LEN_W'(1);
            if (tick_inc >= len)
            begin
                s.tick_count = '0;
                case (s.phase)
                    owbm_pkg::PH_RLOW:  s.phase = owbm_pkg::PH_RWAIT;
                    owbm_pkg::PH_RWAIT:
                    begin
                        s.presence_flag = ~line_level;
                        s.phase         = owbm_pkg::PH_RTAIL;
                    end
                    owbm_pkg::PH_WLEAD: s.phase = owbm_pkg::PH_WBODY;
                    owbm_pkg::PH_WBODY: s.phase = owbm_pkg::PH_WREC;
                    owbm_pkg::PH_DLEAD: s.phase = owbm_pkg::PH_DWAIT;
                    owbm_pkg::PH_DWAIT:
                    begin
                        s.shift_data[s.bit_index] = s.shift_data[s.bit_index] | line_level;
                        s.phase = owbm_pkg::PH_DTAIL;
                    end
                    owbm_pkg::PH_WREC, owbm_pkg::PH_DTAIL:
                    begin
                        if (s.bit_index == 3'd7)
                        begin
                            if (s.phase == owbm_pkg::PH_DTAIL)
                                s.last_read = s.shift_data;
                            s.phase     = owbm_pkg::PH_IDLE;
                            s.bit_index = 3'd0;
                            done        = 1'b1;
                        end
                        else
                        begin
                            s.bit_index = s.bit_index + 3'd1;
                            s.phase     = (s.phase == owbm_pkg::PH_WREC) ?
                                          owbm_pkg::PH_WLEAD : owbm_pkg::PH_DLEAD;
                        end
                    end
                    default:
                    begin
                        // reset tail, or any unused code
                        s.phase = owbm_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                endcase
            end
            else
            begin
                s.tick_count = tick_inc;
            end
        end
    end

    assign state_nxt     = s;
    assign res.drive_low = drive;
    assign res.busy_res  = (s.phase != owbm_pkg::PH_IDLE);
    assign res.done_res  = done;
    assign res.presence  = s.presence_flag;
    assign res.read_byte = s.last_read;
    assign res.rejected  = rej;

endmodule
